/* rtl/llkam_pkg.sv */
// Keyword texts, lengths and flag codes for the log line keyword alert matcher.
`default_nettype none
package llkam_pkg;

   localparam int KwCount   = 11;
   localparam int KwMaxLen  = 22;
   localparam int HistDepth = KwMaxLen - 1;
   localparam int FlagWidth = 4;

   localparam logic [FlagWidth-1:0] FLAG_AUTH = 4'b0001;
   localparam logic [FlagWidth-1:0] FLAG_KTAG = 4'b0010;
   localparam logic [FlagWidth-1:0] FLAG_KERR = 4'b0100;
   localparam logic [FlagWidth-1:0] FLAG_OOM  = 4'b1000;

   typedef logic [8*KwMaxLen-1:0] window_type;
   typedef logic [4:0]            kw_len_type;

   // Last character of each keyword sits in bits [7:0].
   localparam window_type KW_TEXT [KwCount] = '{
      window_type'("failed password"),
      window_type'("authentication failure"),
      window_type'("invalid user"),
      window_type'("failed login"),
      window_type'("kernel:"),
      window_type'("error"),
      window_type'("panic"),
      window_type'("bug"),
      window_type'("out of memory"),
      window_type'("oom"),
      window_type'("killed process")
   };

   localparam kw_len_type KW_LEN [KwCount] = '{
      5'd15, 5'd22, 5'd12, 5'd12, 5'd7, 5'd5, 5'd5, 5'd3, 5'd13, 5'd3, 5'd14
   };

   localparam logic [FlagWidth-1:0] KW_FLAG [KwCount] = '{
      FLAG_AUTH, FLAG_AUTH, FLAG_AUTH, FLAG_AUTH, FLAG_KTAG,
      FLAG_KERR, FLAG_KERR, FLAG_KERR, FLAG_OOM, FLAG_OOM, FLAG_OOM
   };

   function automatic logic [7:0] fold_byte(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5a) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

   // Window byte 0 is the newest; every keyword is checked as ending there.
   function automatic logic [FlagWidth-1:0] kw_flags(input window_type win);
      logic [FlagWidth-1:0] f;
      logic                 hit;
      f = '0;
      for (int i = 0; i < KwCount; i++) begin
         hit = 1'b1;
         for (int k = 0; k < KwMaxLen; k++) begin
            if (k < int'(KW_LEN[i]) && win[8*k +: 8] != KW_TEXT[i][8*k +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            f = f | KW_FLAG[i];
         end
      end
      return f;
   endfunction

endpackage
`default_nettype wire

/* rtl/log_line_keyword_alert_matcher.sv */
// Streaming keyword matcher that raises alert flags at the end of each log message.
//
// Usage: a message enters on the req_ channel one byte per transaction;
// req_tuser marks whether req_tdata holds a byte (low for an empty message)
// and req_tlast ends the message. Bytes are folded to lower case and a
// 22-byte window is compared against eleven keywords in a single pass.
// For each message exactly one rsp_ transaction comes out, carrying the
// authentication failure, kernel error and out of memory flags.
// Throughput: one transaction per cycle, set by the single input register
// to result register compare stage, unless a last one waits on a stalled result.
// The last transaction is held in the input register until the result register
// is free; then the result register takes the flags and drives rsp_tvalid.
// While the receiver stalls with a result pending, bytes of the next
// message keep flowing in; only a second last transaction waits in the
// input register until the result register is free.
// Reset clears the window history, the match flags and both valid flags.
`default_nettype none
module log_line_keyword_alert_matcher (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] message_byte
   input  wire logic       req_tuser,   // [0] has_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // [0] auth_alert, [1] kernel_alert,
                                        // [2] out_of_memory, [7:3] zero
);

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic [7:0]                      s1_byte_ff;
   logic                            s1_has_ff;
   logic                            s1_last_ff;
   logic [7:0]                      hist_ff [llkam_pkg::HistDepth];
   logic [7:0]                      hist_in [llkam_pkg::HistDepth];
   logic [llkam_pkg::FlagWidth-1:0] flags_ff;
   logic [llkam_pkg::FlagWidth-1:0] flags_in;
   logic [llkam_pkg::FlagWidth-1:0] flags_new;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   logic [2:0]                      out_data_ff;
   logic [2:0]                      out_data_in;
   llkam_pkg::window_type           win;
   logic                            s1_adv;
   logic                            req_fire;

   // A last transaction may only leave the input register into a free result slot.
   assign s1_adv     = s1_valid_ff && !(s1_last_ff && out_valid_ff && !rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      win[7:0] = llkam_pkg::fold_byte(s1_byte_ff);
      for (int k = 0; k < llkam_pkg::HistDepth; k++) begin
         win[8*(k+1) +: 8] = hist_ff[k];
      end
   end

   always_comb begin
      flags_new = flags_ff;
      if (s1_has_ff) begin
         flags_new = flags_ff | llkam_pkg::kw_flags(win);
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      hist_in      = hist_ff;
      flags_in     = flags_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (s1_adv) begin
         s1_valid_in = 1'b0;
         if (s1_last_ff) begin
            // Report and clear for the next message.
            out_valid_in = 1'b1;
            out_data_in  = {
               (flags_new & llkam_pkg::FLAG_OOM) != '0,
               ((flags_new & llkam_pkg::FLAG_KTAG) != '0)
                  && ((flags_new & llkam_pkg::FLAG_KERR) != '0),
               (flags_new & llkam_pkg::FLAG_AUTH) != '0
            };
            flags_in = '0;
            for (int k = 0; k < llkam_pkg::HistDepth; k++) begin
               hist_in[k] = 8'd0;
            end
         end else begin
            flags_in = flags_new;
            if (s1_has_ff) begin
               for (int k = 0; k < llkam_pkg::HistDepth; k++) begin
                  hist_in[k] = win[8*k +: 8];
               end
            end
         end
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
         for (int k = 0; k < llkam_pkg::HistDepth; k++) begin
            hist_ff[k] <= 8'd0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
         hist_ff      <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      if (req_fire) begin
         s1_byte_ff <= req_tdata;
         s1_has_ff  <= req_tuser;
         s1_last_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_data_ff};

`ifndef SYNTHESIS
   a_rsp_from_last : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("result raised without a last transaction");

   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (flags_ff == '0 && hist_ff[0] == 8'd0))
      else $error("state not cleared after last transaction");

   a_last_held : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && out_valid_ff && !rsp_tready)
         |=> (s1_valid_ff && s1_last_ff))
      else $error("last transaction lost while result stalled");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the log line keyword alert matcher.
`timescale 1ns / 100ps
`default_nettype none

module tb;

   localparam int ClockHalf  = 10;
   localparam int CycleLimit = 400000;
   localparam int WinLen     = llkam_pkg::HistDepth + 1;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] message_byte
   logic       req_tuser = 1'b0;    // [0] has_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] auth_alert, [1] kernel_alert, [2] out_of_memory

   typedef struct packed {
      logic out_of_memory;
      logic kernel_alert;
      logic auth_alert;
   } alert_flags_type;

   string keyword_text [11] = '{
      "failed password", "authentication failure", "invalid user", "failed login",
      "kernel:", "error", "panic", "bug", "out of memory", "oom", "killed process"
   };

   logic [3:0] keyword_flag [11] = '{
      llkam_pkg::FLAG_AUTH, llkam_pkg::FLAG_AUTH, llkam_pkg::FLAG_AUTH,
      llkam_pkg::FLAG_AUTH, llkam_pkg::FLAG_KTAG, llkam_pkg::FLAG_KERR,
      llkam_pkg::FLAG_KERR, llkam_pkg::FLAG_KERR, llkam_pkg::FLAG_OOM,
      llkam_pkg::FLAG_OOM, llkam_pkg::FLAG_OOM
   };

   class alert_scoreboard_type;
      logic [7:0]      history [llkam_pkg::HistDepth];
      logic [3:0]      seen_flags;
      alert_flags_type alerts_due [$];
      int              failures;

      function new();
         clear_message();
         failures = 0;
      endfunction

      function void clear_message();
         foreach (history[k]) history[k] = 8'h00;
         seen_flags = '0;
      endfunction

      function logic [7:0] to_lower(logic [7:0] b);
         if (b >= "A" && b <= "Z") begin
            return b + 8'd32;
         end
         return b;
      endfunction

      function int pending();
         return alerts_due.size();
      endfunction

      // Predict the effect of one accepted input transaction.
      function void note_transaction(logic [7:0] data, logic has_byte, logic is_last);
         logic [7:0]      win [WinLen];
         alert_flags_type alert;
         int              len;
         logic            hit;
         if (has_byte) begin
            win[0] = to_lower(data);
            for (int k = 1; k < WinLen; k++) win[k] = history[k-1];
            for (int i = 0; i < 11; i++) begin
               len = keyword_text[i].len();
               hit = 1'b1;
               for (int k = 0; k < len; k++) begin
                  if (win[k] != keyword_text[i][len-1-k]) hit = 1'b0;
               end
               if (hit) seen_flags = seen_flags | keyword_flag[i];
            end
            for (int k = 0; k < llkam_pkg::HistDepth; k++) history[k] = win[k];
         end
         if (is_last) begin
            alert.auth_alert    = (seen_flags & llkam_pkg::FLAG_AUTH) != 0;
            alert.kernel_alert  = ((seen_flags & llkam_pkg::FLAG_KTAG) != 0) &&
                                  ((seen_flags & llkam_pkg::FLAG_KERR) != 0);
            alert.out_of_memory = (seen_flags & llkam_pkg::FLAG_OOM) != 0;
            alerts_due = {alerts_due, alert};
            clear_message();
         end
      endfunction

      function void check_result(logic [7:0] data);
         alert_flags_type want;
         if (alerts_due.size() == 0) begin
            $display("%0t: unexpected result transaction, actual %h", $time, data);
            failures++;
            return;
         end
         want = alerts_due.pop_front();
         if (data[0] !== want.auth_alert) begin
            $display("%0t: auth_alert expected %b actual %b", $time, want.auth_alert,
                     data[0]);
            failures++;
         end
         if (data[1] !== want.kernel_alert) begin
            $display("%0t: kernel_alert expected %b actual %b", $time, want.kernel_alert,
                     data[1]);
            failures++;
         end
         if (data[2] !== want.out_of_memory) begin
            $display("%0t: out_of_memory expected %b actual %b", $time,
                     want.out_of_memory, data[2]);
            failures++;
         end
         if (data[7:3] !== 5'b0) begin
            $display("%0t: padding expected %b actual %b", $time, 5'b0, data[7:3]);
            failures++;
         end
      endfunction

      function void report_leftover();
         if (alerts_due.size() != 0) begin
            $display("%0t: %0d results never arrived, expected next %b", $time,
                     alerts_due.size(), alerts_due[0]);
            failures++;
         end
      endfunction
   endclass

   alert_scoreboard_type sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_cycles_req = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int items_sent = 0;

   log_line_keyword_alert_matcher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAIL log_line_keyword_alert_matcher");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (hold_cycles_req != 0) begin
         hold_left = hold_cycles_req;
         hold_cycles_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check results first so a result never meets an expectation noted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_transaction(req_tdata, req_tuser, req_tlast);
      end
   end

   task automatic send_item(input logic [7:0] data, input logic has_byte, input logic is_last);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= has_byte;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, i == s.len() - 1);
   endtask

   // Hold the input off until every expected result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic void add_filler(ref logic [7:0] q[$], input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 15) q = {q, 8'h20};
         else if (pick < 65) q = {q, 8'($urandom_range(97, 122))};
         else if (pick < 80) q = {q, 8'($urandom_range(64, 91))};
         else q = {q, 8'($urandom_range(255))};
      end
   endfunction

   // Append a keyword in random case; a broken one has a character altered or dropped.
   function automatic void add_keyword(ref logic [7:0] q[$], input string kw,
                                       input bit broken);
      logic [7:0] c;
      int         spoil;
      int         len;
      len = kw.len();
      spoil = broken ? $urandom_range(len) : -1;
      for (int i = 0; i < len; i++) begin
         c = kw[i];
         if (c >= "a" && c <= "z" && $urandom_range(1) == 1) c = c - 8'd32;
         if (i == spoil) c = c ^ 8'h01;
         if (!(broken && spoil == len && i == len - 1)) q = {q, c};
      end
   endfunction

   task automatic send_message();
      logic [7:0] text [$];
      int         style;
      int         pieces;
      bit         tail_empty;
      style = $urandom_range(99);
      tail_empty = ($urandom_range(99) < 15);
      if (style < 60) begin
         add_filler(text, $urandom_range(6));
         if ($urandom_range(99) < 30) begin
            if ($urandom_range(1) == 1) begin
               add_keyword(text, "kernel:", 0);
               add_filler(text, $urandom_range(5));
               add_keyword(text, keyword_text[$urandom_range(5, 7)], 0);
            end else begin
               add_keyword(text, keyword_text[$urandom_range(5, 7)], 0);
               add_filler(text, $urandom_range(5));
               add_keyword(text, "kernel:", 0);
            end
         end else begin
            pieces = $urandom_range(1, 3);
            for (int p = 0; p < pieces; p++) begin
               add_keyword(text, keyword_text[$urandom_range(10)], 0);
               add_filler(text, $urandom_range(6));
            end
         end
      end else if (style < 75) begin
         pieces = $urandom_range(1, 3);
         for (int p = 0; p < pieces; p++) begin
            add_filler(text, $urandom_range(4));
            add_keyword(text, keyword_text[$urandom_range(10)], 1);
         end
      end else if (style < 90) begin
         for (int i = $urandom_range(1, 30); i > 0; i--) text = {text, 8'($urandom_range(255))};
      end else begin
         tail_empty = 1'b1;
      end
      for (int i = 0; i < text.size(); i++) begin
         // Drop in an ignored no-byte transaction now and then.
         if ($urandom_range(99) < 5) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         send_item(text[i], 1'b1, !tail_empty && i == text.size() - 1);
         items_sent++;
      end
      if (tail_empty) begin
         send_item(8'($urandom_range(255)), 1'b0, 1'b1);
         items_sent++;
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      items_sent = 0;
      while (items_sent < target) send_message();
      drain_results();
   endtask

   initial begin
      int guard;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty message, folding, byte extremes, ignored items, kernel tag after word.
      send_item(8'hff, 1'b0, 1'b1);
      send_text("OOM");
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'ha5, 1'b0, 1'b0);
      send_item("Z", 1'b1, 1'b1);
      send_text("bugKernel:");
      send_item("o", 1'b1, 1'b0);
      send_item("o", 1'b1, 1'b0);
      send_item(8'h3c, 1'b0, 1'b0);
      send_item("m", 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      drain_results();

      // Fill the block behind a long receiver hold-off.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles_req = 300;
      items_sent = 0;
      while (items_sent < 80) send_message();
      drain_results();

      run_phase(0, 0, 270);
      run_phase(49, 0, 300);
      run_phase(0, 49, 300);
      run_phase(15, 15, 300);

      guard = 0;
      while (sb.pending() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      sb.report_leftover();
      if (sb.failures == 0) begin
         $display("PASS log_line_keyword_alert_matcher");
      end else begin
         $display("FAIL log_line_keyword_alert_matcher");
      end
      $finish;
   end

endmodule

`default_nettype wire
